// File: rtl/cwrms_pkg.sv
// Shared types and constants for the calibrated windowed RMS meter.
// Used by the register block and the top level; no dependencies.

package cwrms_pkg;

	// Field and datapath widths.
	localparam int CUR_W   = 24;
	localparam int RMS_W   = 24;
	localparam int CNT_W   = 16;
	localparam int GAIN_W  = 32;
	localparam int MUL_W   = 33;
	localparam int PROD_W  = 64;
	localparam int SUM_W   = 64;
	localparam int DIV_W   = CNT_W + 1;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int SUB_W   = REM_W + 1;
	localparam int STEP_W  = 6;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// Iteration counts of the divider and the square root.
	localparam int DIV_STEPS  = SUM_W;
	localparam int SQRT_STEPS = ROOT_W;
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);

	// Saturation limits of the calibrated current.
	localparam logic signed [PROD_W-1:0] CUR_MAX_C = 64'sd8388607;
	localparam logic signed [PROD_W-1:0] CUR_MIN_C = -64'sd8388608;

	// Register reset values.
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 32'd28421;
	localparam logic [CUR_W-1:0]  OFFSET_RESET = 24'hFFFC71;
	localparam logic [CNT_W-1:0]  WINDOW_RESET = 16'd4000;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_GAIN   = 2'd0,
		REG_OFFSET = 2'd1,
		REG_WINDOW = 2'd2
	} cwrms_reg_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [CUR_W-1:0]  offset;
		logic [CNT_W-1:0]  window;
	} cwrms_cfg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_RAW,
		S_SCALE,
		S_MUL_SQ,
		S_ACCUM,
		S_DIV,
		S_SQRT,
		S_EMIT
	} cwrms_state_t;

endpackage

// File: rtl/cwrms_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Standalone; the result widths match cwrms_pkg.

interface cwrms_sample_if #(parameter int SAMPLE_BITS = 12) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);
endinterface

interface cwrms_result_if ();
	logic               valid;
	logic               ready;
	logic signed [23:0] current_value;
	logic [23:0]        rms_value;
	logic               rms_ready;

	modport source (output valid, output current_value, output rms_value, output rms_ready,
		input ready);
	modport sink (input valid, input current_value, input rms_value, input rms_ready,
		output ready);
endinterface

// File: rtl/cwrms_regs.sv
// APB-style configuration registers: gain, offset and window length.
// Depends on cwrms_pkg for widths, reset values and register indexes.

module cwrms_regs import cwrms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cwrms_cfg_t        cfg
);

	logic [GAIN_W-1:0] gain_q;
	logic [CUR_W-1:0]  offset_q;
	logic [CNT_W-1:0]  window_q;
	logic              wr_en;

	// The port never stalls, so a write lands in its access cycle.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
			window_q <= WINDOW_RESET;
		end else if (wr_en) begin
			case (paddr[ADDR_W-1:2])
				REG_GAIN: begin
					gain_q <= pwdata[GAIN_W-1:0];
				end
				REG_OFFSET: begin
					offset_q <= pwdata[CUR_W-1:0];
				end
				REG_WINDOW: begin
					window_q <= pwdata[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_GAIN: begin
				prdata = gain_q;
			end
			REG_OFFSET: begin
				prdata = {{(DATA_W-CUR_W){1'b0}}, offset_q};
			end
			REG_WINDOW: begin
				prdata = {{(DATA_W-CNT_W){1'b0}}, window_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg.gain   = gain_q;
	assign cfg.offset = offset_q;
	assign cfg.window = window_q;

endmodule

// File: rtl/calibrated_windowed_rms_meter_unit.sv
// Calibrated windowed RMS meter. Each sample item is calibrated to a Q8.16 current
// (raw*gain rounded, plus offset, saturated) and its square is accumulated; when the
// count reaches the window length, the mean square is divided out and its floor square
// root becomes the new RMS. An item that does not close a window passes the raw multiply,
// scale, square, accumulate and emit states to the result register, the emit state waiting
// while that register holds an untaken result; one that closes a window also passes the
// divider, 64 one-bit steps, and the square root, 32 two-bit steps, all on one shared
// subtractor. A new item is taken only once the last is loaded. The one multiplier serves
// both the calibration product and the square.
// The result sits in an output register, so a new sample is taken while it waits.
// Depends on cwrms_pkg, cwrms_if and cwrms_regs.

module calibrated_windowed_rms_meter_unit import cwrms_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cwrms_sample_if.sink          sample_ch,
	cwrms_result_if.source        result_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready
);

	cwrms_cfg_t cfg;

	cwrms_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0]    raw_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CUR_W-1:0]   cur_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          count_q;
	logic [RMS_W-1:0]          last_rms_q;
	logic [SUM_W-1:0]          work_q;
	logic [DIV_W-1:0]          divisor_q;
	logic [REM_W-1:0]          rem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [STEP_W-1:0]         step_q;
	logic                      done_q;
	logic                      out_valid_q;
	logic signed [CUR_W-1:0]   cur_out_q;
	logic [RMS_W-1:0]          rms_out_q;
	logic                      rdy_out_q;

	logic                      accept;
	logic                      emit_load;

	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	logic signed [PROD_W-1:0]  rnd;
	logic signed [PROD_W-1:0]  cal;
	logic signed [CUR_W-1:0]   cur_sat;

	logic [SUM_W-1:0]          sum_new;
	logic [DIV_W-1:0]          cnt_new;
	logic [CNT_W-1:0]          win_eff;
	logic                      win_done;

	logic [SUB_W-1:0]          sub_a;
	logic [SUB_W-1:0]          sub_b;
	logic [SUB_W:0]            sub_diff;
	logic                      borrow;

	// Configuration registers.
	cwrms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Shared multiplier: raw times gain, then current times itself.
	always_comb begin
		if (state_q == S_MUL_RAW) begin
			mul_a = $signed({{(MUL_W-SAMPLE_BITS){1'b0}}, raw_q});
			mul_b = $signed({{(MUL_W-GAIN_W){cfg.gain[GAIN_W-1]}}, cfg.gain});
		end else begin
			mul_a = $signed({{(MUL_W-CUR_W){cur_q[CUR_W-1]}}, cur_q});
			mul_b = $signed({{(MUL_W-CUR_W){cur_q[CUR_W-1]}}, cur_q});
		end
		mul_p = mul_a * mul_b;
	end

	// Round Q8.24 to Q8.16 half up, add the offset and saturate.
	always_comb begin
		rnd = (prod_q + 64'sd128) >>> 8;
		cal = rnd + $signed({{(PROD_W-CUR_W){cfg.offset[CUR_W-1]}}, cfg.offset});
		if (cal > CUR_MAX_C) begin
			cur_sat = CUR_MAX_C[CUR_W-1:0];
		end else if (cal < CUR_MIN_C) begin
			cur_sat = CUR_MIN_C[CUR_W-1:0];
		end else begin
			cur_sat = cal[CUR_W-1:0];
		end
	end

	// Accumulation and window check; a zero window length acts as one.
	always_comb begin
		sum_new  = sum_q + $unsigned(prod_q);
		cnt_new  = {1'b0, count_q} + DIV_W'(1);
		win_eff  = (cfg.window == '0) ? CNT_W'(1) : cfg.window;
		win_done = cnt_new >= {1'b0, win_eff};
	end

	// Shared subtractor: restoring divide step or square-root digit step.
	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {rem_q[REM_W-2:0], work_q[SUM_W-1 -: 2]};
			sub_b = {{(SUB_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		end else begin
			sub_a = {{(SUB_W-DIV_W-1){1'b0}}, rem_q[DIV_W-1:0], work_q[SUM_W-1]};
			sub_b = {{(SUB_W-DIV_W){1'b0}}, divisor_q};
		end
		sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
		borrow   = sub_diff[SUB_W];
	end

	// Sequencer next state and handshake controls.
	always_comb begin
		state_d   = state_q;
		emit_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (sample_ch.valid) begin
					state_d = S_MUL_RAW;
				end
			end
			S_MUL_RAW: begin
				state_d = S_SCALE;
			end
			S_SCALE: begin
				state_d = S_MUL_SQ;
			end
			S_MUL_SQ: begin
				state_d = S_ACCUM;
			end
			S_ACCUM: begin
				state_d = win_done ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				if (step_q == SQRT_LAST) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || result_ch.ready) begin
					emit_load = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: accumulator, count, step counter, held RMS, window-done flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			last_rms_q  <= '0;
			step_q      <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ACCUM: begin
					step_q <= '0;
					done_q <= win_done;
					if (win_done) begin
						sum_q   <= '0;
						count_q <= '0;
					end else begin
						sum_q   <= sum_new;
						count_q <= cnt_new[CNT_W-1:0];
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
				end
				S_SQRT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == SQRT_LAST) begin
						last_rms_q <= {root_q[RMS_W-2:0], ~borrow};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					raw_q <= sample_ch.raw_sample;
				end
			end
			S_MUL_RAW, S_MUL_SQ: begin
				prod_q <= mul_p[PROD_W-1:0];
			end
			S_SCALE: begin
				cur_q <= cur_sat;
			end
			S_ACCUM: begin
				work_q    <= sum_new;
				divisor_q <= cnt_new;
				rem_q     <= '0;
				root_q    <= '0;
			end
			S_DIV: begin
				work_q <= {work_q[SUM_W-2:0], ~borrow};
				if (step_q == DIV_LAST) begin
					rem_q <= '0;
				end else if (borrow) begin
					rem_q <= sub_a[REM_W-1:0];
				end else begin
					rem_q <= sub_diff[REM_W-1:0];
				end
			end
			S_SQRT: begin
				work_q <= {work_q[SUM_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], ~borrow};
				rem_q  <= borrow ? sub_a[REM_W-1:0] : sub_diff[REM_W-1:0];
			end
			S_EMIT: begin
				if (emit_load) begin
					cur_out_q <= cur_q;
					rms_out_q <= last_rms_q;
					rdy_out_q <= done_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.current_value = cur_out_q;
	assign result_ch.rms_value     = rms_out_q;
	assign result_ch.rms_ready     = rdy_out_q;

	// The divider never runs with a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (divisor_q != '0))
		else $error("divide step with zero divisor");

	// The partial remainder stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {{(REM_W-DIV_W){1'b0}}, divisor_q}))
		else $error("divide remainder out of range");

	// The accumulator and count are already cleared while a window result is computed.
	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV || state_q == S_SQRT) |-> (sum_q == '0 && count_q == '0))
		else $error("accumulator not cleared during window result");

	// The final root fits the RMS field.
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT && step_q == SQRT_LAST) |-> (root_q[ROOT_W-2:RMS_W-1] == '0))
		else $error("square root exceeds RMS width");

	// An item is only taken with the sequencer at rest.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL_RAW))
		else $error("accepted item did not start the sequence");

endmodule
